[src/pcmax_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmax_pkg: shared types and constants of the per-column max row size tracker
// Field widths, register codes, the sequencer state type and fixed limits.
// ---------------------------------------------------------------------------
package pcmax_pkg;

	// Column count and field widths
	localparam int NumColumns = 64;
	localparam int ColW       = 6;
	localparam int FpW        = 48;
	localparam int RowW       = 24;
	localparam int SumW       = 54;
	localparam int InW        = 80;   // 78 payload bits padded to whole bytes
	localparam int OutW       = 112;  // 110 payload bits padded to whole bytes
	localparam int CfgW       = 64;
	localparam int AddrW      = 4;

	// Restoring divider steps: one quotient bit per cycle
	localparam int DivSteps   = FpW;
	localparam int DivCntW    = 6;

	// Estimate floor while a watched column is still missing
	localparam logic [SumW-1:0] FloorVal = SumW'(64'd1 << 20);

	// Columns that exist: masks bits at or above NumColumns
	localparam logic [63:0] ColRange = ~64'd0 >> (64 - NumColumns);

	// Register index codes (selected by address bit 3)
	localparam logic RegVarLen = 1'b0;
	localparam logic RegProj   = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

[src/pcmax_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcmax_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module pcmax_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[src/pcmax_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcmax_divider: iterative restoring divider
// Footprint over row count, one quotient bit per cycle; done pulses once.
// ---------------------------------------------------------------------------
module pcmax_divider
	import pcmax_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [FpW-1:0]  dividend,
	input  wire logic [RowW-1:0] divisor,
	output logic                 done,
	output logic [FpW-1:0]       quotient
);

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [FpW-1:0]     quo_q;
	logic [RowW-1:0]    rem_q;
	logic [RowW-1:0]    div_q;

	logic [RowW:0]      shifted;
	logic [RowW+1:0]    trial;
	logic               fits;

	// One trial subtract per step
	always_comb begin
		shifted = {rem_q, quo_q[FpW-1]};
		trial   = {1'b0, shifted} - {2'b00, div_q};
		fits    = ~trial[RowW+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DivCntW'(1);
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[FpW-2:0], fits};
			rem_q <= fits ? trial[RowW-1:0] : shifted[RowW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[src/per_column_max_row_size_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an applied update runs the 48-step bit-serial divider, then the compare,
//   sum and finish states; an ignored update (zero rows) goes straight to finish.
// Flow: one item at a time; the next input transfer follows the result load, and the
//   load waits while an earlier result is still held on the output.
// Reset: arst_n clears valid marks, running sum, masks (projected all ones), sequencer.
//   The per-column maxima RAM is not cleared; entries are read only when marked valid.
// ---------------------------------------------------------------------------
// per_column_max_row_size_tracker: per-column max bytes-per-row and their sum
// Divides footprint by rows, keeps a per-column maximum and the running sum.
// ---------------------------------------------------------------------------
module per_column_max_row_size_tracker
	import pcmax_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Input stream
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// [5:0] column_index, [53:6] footprint_bytes, [77:54] row_count
	input  wire logic [InW-1:0]   s_axis_tdata,
	// Result stream
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// [53:0] size_estimate, [107:54] sum_of_maxima, [108] all_materialized,
	// [109] update_applied
	output logic      [OutW-1:0]  m_axis_tdata,
	// Configuration port
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [CfgW-1:0]  pwdata,
	output logic      [CfgW-1:0]  prdata,
	output logic                  pready
);

	state_t              state_q;
	logic [ColW-1:0]     col_q;
	logic                applied_q;
	logic [63:0]         valid_q;
	logic [SumW-1:0]     sum_q;
	logic [CfgW-1:0]     var_len_q;
	logic [CfgW-1:0]     proj_q;
	logic                upd_q;
	logic [FpW-1:0]      delta_q;
	logic                out_valid_q;
	logic [OutW-1:0]     out_data_q;

	logic                in_xfer;
	logic [ColW-1:0]     in_col;
	logic [FpW-1:0]      in_fp;
	logic [RowW-1:0]     in_rows;
	logic                in_applied;
	logic                div_start;
	logic                div_done;
	logic [FpW-1:0]      quotient;
	logic [FpW-1:0]      ram_rdata;
	logic [FpW-1:0]      old_max;
	logic [FpW:0]        diff;
	logic                cmp_upd;
	logic                fin_load;
	logic [63:0]         watched;
	logic                all_mat;
	logic [SumW-1:0]     est;
	logic                cfg_wr;

	// Input unpacking and update qualification
	assign in_col     = s_axis_tdata[ColW-1:0];
	assign in_fp      = s_axis_tdata[ColW+FpW-1:ColW];
	assign in_rows    = s_axis_tdata[ColW+FpW+RowW-1:ColW+FpW];
	assign in_applied = (in_rows != '0) && ({1'b0, in_col} < (ColW+1)'(NumColumns));
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign div_start  = in_xfer && in_applied;

	pcmax_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_fp),
		.divisor  (in_rows),
		.done     (div_done),
		.quotient (quotient)
	);

	pcmax_ram #(
		.WIDTH (FpW),
		.DEPTH (NumColumns)
	) u_max_ram (
		.clk   (clk),
		.we    (state_q == ST_SUM && upd_q),
		.waddr (col_q),
		.wdata (quotient),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// Compare new bytes-per-row against the stored maximum
	always_comb begin
		old_max = valid_q[col_q] ? ram_rdata : '0;
		diff    = {1'b0, quotient} - {1'b0, old_max};
		cmp_upd = !valid_q[col_q] || (!diff[FpW] && (diff[FpW-1:0] != '0));
	end

	// Materialization and estimate
	always_comb begin
		watched = var_len_q & proj_q & ColRange;
		all_mat = ((watched & ~valid_q) == '0);
		est     = (!all_mat && (sum_q < FloorVal)) ? FloorVal : sum_q;
	end

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= in_applied ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q     <= in_col;
			applied_q <= in_applied;
		end
		if (state_q == ST_CMP) begin
			upd_q   <= cmp_upd;
			delta_q <= diff[FpW-1:0];
		end
	end

	// Valid marks and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sum_q   <= '0;
		end else if (state_q == ST_SUM && upd_q) begin
			valid_q[col_q] <= 1'b1;
			sum_q          <= sum_q + SumW'(delta_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_data_q <= {2'b00, applied_q, all_mat, sum_q, est};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_len_q <= '0;
			proj_q    <= '1;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				RegVarLen: var_len_q <= pwdata;
				RegProj:   proj_q    <= pwdata;
				default:   var_len_q <= var_len_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			RegVarLen: prdata = var_len_q;
			RegProj:   prdata = proj_q;
			default:   prdata = '0;
		endcase
	end

`ifndef SYNTH
	// Divider is started only from idle on an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> state_q == ST_IDLE)
		else $error("divider started outside idle");

	// Running sum never decreases
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q >= $past(sum_q))
		else $error("running sum decreased");

	// A result is never loaded over one that is still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten");

	// An applied update leaves the column marked valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && upd_q) |=> valid_q[$past(col_q)])
		else $error("column not marked valid after update");

	// Divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside divide state");
`endif

endmodule
`default_nettype wire

[tb/row_check.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// row_check: result predictor and comparator for the row size tracker
// Watches the input, result and register channels, keeps its own copy of the
// per-column maxima, valid marks, running sum and masks, and compares every
// result transfer field by field with the oldest expected result.
// ---------------------------------------------------------------------------
module row_check
	import pcmax_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [InW-1:0]   s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OutW-1:0]  m_axis_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [CfgW-1:0]  pwdata,
	input  logic [CfgW-1:0]  prdata,
	input  logic             pready,
	output int               fail_count,
	output int               pending,
	output int               results_seen,
	output int               applied_seen,
	output int               floored_seen,
	output int               complete_seen
);

	typedef struct packed {
		logic [SumW-1:0] est;
		logic [SumW-1:0] sum;
		logic            all_mat;
		logic            applied;
	} row_result_t;

	// Predicted state
	logic [FpW-1:0]  col_max [NumColumns];
	logic [63:0]     col_valid;
	logic [SumW-1:0] run_sum;
	logic [CfgW-1:0] var_len;
	logic [CfgW-1:0] proj;
	row_result_t     exp_q [$];

	task automatic cmp_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t row_check: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// Apply one update and queue the result it must produce
	task automatic predict_row_size(input logic [ColW-1:0] col, input logic [FpW-1:0] fp,
		input logic [RowW-1:0] rows);
		row_result_t r;
		logic [FpW-1:0] per_row;
		logic [63:0] watched;
		r.applied = 1'b0;
		if (rows != '0 && col < NumColumns) begin
			per_row   = fp / rows;
			r.applied = 1'b1;
			if (!col_valid[col]) begin
				col_valid[col] = 1'b1;
				col_max[col]   = per_row;
				run_sum        = run_sum + SumW'(per_row);
			end else if (col_max[col] < per_row) begin
				run_sum      = run_sum - SumW'(col_max[col]) + SumW'(per_row);
				col_max[col] = per_row;
			end
		end
		watched   = var_len & proj & ColRange;
		r.all_mat = ((watched & ~col_valid) == '0);
		r.sum     = run_sum;
		r.est     = (!r.all_mat && run_sum < FloorVal) ? FloorVal : run_sum;
		exp_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid     = '0;
			run_sum       = '0;
			var_len       = '0;
			proj          = '1;
			exp_q.delete();
			fail_count    = 0;
			pending       = 0;
			results_seen  = 0;
			applied_seen  = 0;
			floored_seen  = 0;
			complete_seen = 0;
		end else begin
			// Register writes update the local copy; reads are checked against it
			if (psel && penable && pready && pwrite) begin
				case (paddr[3])
					RegVarLen: var_len = pwdata;
					RegProj:   proj = pwdata;
				endcase
			end
			if (psel && penable && pready && !pwrite) begin
				case (paddr[3])
					RegVarLen: cmp_field("var_length_mask read", var_len, prdata);
					RegProj:   cmp_field("projected_mask read", proj, prdata);
				endcase
			end

			// Result transfer: compare with the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_q.size() == 0) begin
					fail_count++;
					$display("%0t row_check: result with none expected, actual %h",
						$time, m_axis_tdata);
				end else begin
					row_result_t want;
					want = exp_q.pop_front();
					cmp_field("size_estimate", 64'(want.est),
						64'(m_axis_tdata[SumW-1:0]));
					cmp_field("sum_of_maxima", 64'(want.sum),
						64'(m_axis_tdata[2*SumW-1:SumW]));
					cmp_field("all_materialized", 64'(want.all_mat),
						64'(m_axis_tdata[2*SumW]));
					cmp_field("update_applied", 64'(want.applied),
						64'(m_axis_tdata[2*SumW+1]));
					results_seen++;
					if (want.applied)
						applied_seen++;
					if (want.all_mat)
						complete_seen++;
					if (want.sum < FloorVal && !want.all_mat)
						floored_seen++;
				end
			end

			// Input transfer
			if (s_axis_tvalid && s_axis_tready)
				predict_row_size(s_axis_tdata[ColW-1:0], s_axis_tdata[ColW +: FpW],
					s_axis_tdata[ColW+FpW +: RowW]);

			pending = exp_q.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the per-column max row size tracker
// Sends directed and random column size reports in bursts, throttles the
// result side, rewrites both masks between phases and reports the outcome
// of the checks done in row_check.
// ---------------------------------------------------------------------------
module testbench;
	import pcmax_pkg::*;

	typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// [5:0] column_index, [53:6] footprint_bytes, [77:54] row_count
	logic [InW-1:0]   s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// [53:0] size_estimate, [107:54] sum_of_maxima, [108] all_materialized,
	// [109] update_applied
	logic [OutW-1:0]  m_axis_tdata;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [CfgW-1:0]  pwdata;
	logic [CfgW-1:0]  prdata;
	logic             pready;

	int fail_count, pending, results_seen, applied_seen, floored_seen, complete_seen;

	rx_mode_t rx_mode = RX_ALWAYS;
	bit       hold_go = 1'b0;
	bit       tx_steady = 1'b0;
	int       burst_left = 1;
	int       items_sent = 0;

	per_column_max_row_size_tracker dut (.*);

	row_check check (.*);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: one long hold-off on request, otherwise the current stall mode
	initial begin
		logic [15:0] rdy_pat;
		int          pat_age;
		bit          hold_done;
		rdy_pat       = 16'hB5A7;
		pat_age       = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_PATTERN: begin
					m_axis_tready <= rdy_pat[0];
					rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
					pat_age++;
					if (pat_age == 64) begin
						pat_age = 0;
						rdy_pat = 16'($urandom) | 16'h0001;
					end
				end
				default: m_axis_tready <= ($urandom_range(3, 0) != 0);
			endcase
		end
	end

	// Register access: setup cycle, access cycle, then idle with the select dropped
	task automatic reg_access(input logic wr, input logic reg_code,
		input logic [CfgW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_code, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Drain all results, then rewrite both masks and read them back
	task automatic set_masks(input logic [CfgW-1:0] var_len, input logic [CfgW-1:0] proj);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		reg_access(1'b1, RegVarLen, var_len);
		reg_access(1'b0, RegVarLen, '0);
		reg_access(1'b1, RegProj, proj);
		reg_access(1'b0, RegProj, '0);
	endtask

	// One input transfer, then, unless sending steadily, a random gap when the current burst runs out
	task automatic send_report(input logic [ColW-1:0] col, input logic [FpW-1:0] fp,
		input logic [RowW-1:0] rows);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, rows, fp, col};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(24, 1);
			gap = tx_steady ? 0 : $urandom_range(60, 0);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Random report over a column range; footprint and rows at random scales
	task automatic send_random(input int col_lo, input int col_hi);
		logic [ColW-1:0] col;
		logic [FpW-1:0]  fp;
		logic [RowW-1:0] rows;
		col = ColW'($urandom_range(col_hi, col_lo));
		fp  = FpW'({$urandom, $urandom});
		if ($urandom_range(3, 0) != 0)
			fp = fp >> $urandom_range(47, 0);
		if ($urandom_range(9, 0) == 0)
			rows = '0;
		else
			rows = RowW'($urandom) >> $urandom_range(23, 0);
		send_report(col, fp, rows);
	endtask

	task automatic random_phase(input int col_lo, input int col_hi, input int count);
		repeat (count) send_random(col_lo, col_hi);
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: watch columns 0, 1 and 63
		set_masks('1, 64'h8000_0000_0000_0003);
		send_report(6'd0, 48'd0, 24'd1);                      // zero per row, floor
		send_report(6'd0, 48'hFFFF_FFFF_FFFF, 24'd0);         // zero rows ignored
		send_report(6'd1, 48'd1000, 24'hFF_FFFF);             // first update, truncates to 0
		send_report(6'd1, 48'd999_999, 24'd1);                // larger replaces
		send_report(6'd1, 48'd500, 24'd1);                    // smaller kept out
		send_report(6'd1, 48'd999_999, 24'd1);                // equal kept out
		send_report(6'd0, 48'd148_730, 24'd3);                // sum 999 above the floor
		send_report(6'd0, 48'd148_731, 24'd3);                // sum 1000 above the floor
		send_report(6'd0, 48'd148_736, 24'd3);                // sum 1001 above the floor
		send_report(6'd63, 48'd7, 24'd8);                     // watched set now complete
		send_report(6'd62, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
		send_report(6'd62, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
		send_report(6'd2, 48'hFFFF_FFFF_FFFF, 24'd1);         // largest per-row value
		send_report(6'd3, 48'h8000_0000_0000, 24'h80_0000);
		send_report(6'd4, 48'h5555_5555_5555, 24'hAA_AAAA);
		send_report(6'd5, 48'hAAAA_AAAA_AAAA, 24'h55_5555);
		send_report(6'd6, 48'd0, 24'hFF_FFFF);
		send_report(6'd63, 48'hFFFF_FFFF_FFFF, 24'd1);
		send_report(6'd0, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
		send_report(6'd7, 48'd12_345, 24'd0);

		// Upper half projected and partly unreported
		rx_mode = RX_PATTERN;
		set_masks({$urandom, $urandom}, 64'hFFFF_FFFF_0000_0000);
		random_phase(8, 40, 400);

		// Nothing variable length
		rx_mode = RX_RANDOM;
		set_masks('0, {$urandom, $urandom});
		random_phase(0, 63, 400);

		// Every column watched; long result hold-off with the input kept busy
		rx_mode = RX_ALWAYS;
		set_masks('1, '1);
		tx_steady = 1'b1;
		hold_go   = 1'b1;
		random_phase(0, 63, 40);
		tx_steady = 1'b0;
		rx_mode   = RX_RANDOM;
		random_phase(0, 63, 460);

		// Nothing projected
		rx_mode = RX_PATTERN;
		set_masks({$urandom, $urandom}, '0);
		random_phase(0, 63, 500);

		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);

		$display("Run covered %0d reports, %0d results checked, %0d updates applied,",
			items_sent, results_seen, applied_seen);
		$display("%0d results below the floor while incomplete, %0d with all columns present.",
			floored_seen, complete_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
src/pcmax_pkg.sv
src/pcmax_ram.sv
src/pcmax_divider.sv
src/per_column_max_row_size_tracker.sv
tb/row_check.sv
tb/testbench.sv
